[hdl/lmmse_mimo_2x2_detector_macros.svh]
// Assertion macros shared by the LMMSE 2x2 detector RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef LMMSE_MIMO_2X2_DETECTOR_MACROS_SVH
`define LMMSE_MIMO_2X2_DETECTOR_MACROS_SVH

// check a condition at every clock edge outside reset
`define LMD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the cycle after an antecedent
`define LMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lmd_pkg.sv]
// Types and constants for the LMMSE 2x2 detector.
// No dependencies; used by every module of the block.
package lmd_pkg;

  localparam int DATA_W      = 16;
  localparam int NUM_IN      = 12;
  localparam int NUM_LANES   = 4;
  localparam int IN_W        = DATA_W * NUM_IN;
  localparam int OUT_W       = DATA_W * NUM_LANES;
  localparam int GRAM_W      = 31;
  localparam int PROD_W      = 2 * GRAM_W;
  localparam int WIDE_W      = 64;
  localparam int OUT_FRAC    = 11;
  localparam int QUO_W       = OUT_FRAC + 6;
  localparam int REM_W       = 80;
  localparam int QUEUE_DEPTH = 8;

  localparam logic signed [34:0] GRAM_ONE = 35'sd4194304;
  localparam logic [QUO_W-1:0] POS_MAX = QUO_W'(32767);
  localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(32768);
  localparam logic [DATA_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic [WIDE_W-1:0]                det;
    logic [NUM_LANES-1:0][WIDE_W-1:0] num;
  } work_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[hdl/lmd_front.sv]
// Front pipeline: Gram matrix, matched filter, determinant and adjugate numerators.
// Depends on lmd_pkg; feeds lmd_queue.
module lmd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [lmd_pkg::IN_W-1:0]  in_data,
  output logic                      push,
  output lmd_pkg::work_t            push_data
);

  localparam int GW = lmd_pkg::GRAM_W;
  localparam int PW = lmd_pkg::PROD_W;
  localparam int WW = lmd_pkg::WIDE_W;

  lmd_pkg::sample_t smp [lmd_pkg::NUM_IN];

  for (genvar i = 0; i < lmd_pkg::NUM_IN; i++) begin : g_unpack
    assign smp[i] = in_data[lmd_pkg::DATA_W*i +: lmd_pkg::DATA_W];
  end

  function automatic logic signed [33:0] cj_re(input lmd_pkg::sample_t ar, ai, br, bi);
    logic signed [31:0] p0, p1;
    p0 = ar * br;
    p1 = ai * bi;
    return 34'(p0) + 34'(p1);
  endfunction

  function automatic logic signed [33:0] cj_im(input lmd_pkg::sample_t ar, ai, br, bi);
    logic signed [31:0] p0, p1;
    p0 = ar * bi;
    p1 = ai * br;
    return 34'(p0) - 34'(p1);
  endfunction

  function automatic logic signed [GW-1:0] rnd4(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = v + 35'sd8;
    return GW'(t >>> 4);
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [GW-1:0] a, b);
    return a * b;
  endfunction

  // stage 1: exact Q.22 sums, rounded to Q.18
  logic signed [34:0] g00, g11, g01re, g01im, z0re, z0im, z1re, z1im;

  always_comb begin
    g00   = 35'(cj_re(smp[4], smp[5], smp[4], smp[5]))
          + 35'(cj_re(smp[8], smp[9], smp[8], smp[9])) + lmd_pkg::GRAM_ONE;
    g11   = 35'(cj_re(smp[6], smp[7], smp[6], smp[7]))
          + 35'(cj_re(smp[10], smp[11], smp[10], smp[11])) + lmd_pkg::GRAM_ONE;
    g01re = 35'(cj_re(smp[4], smp[5], smp[6], smp[7]))
          + 35'(cj_re(smp[8], smp[9], smp[10], smp[11]));
    g01im = 35'(cj_im(smp[4], smp[5], smp[6], smp[7]))
          + 35'(cj_im(smp[8], smp[9], smp[10], smp[11]));
    z0re  = 35'(cj_re(smp[4], smp[5], smp[0], smp[1]))
          + 35'(cj_re(smp[8], smp[9], smp[2], smp[3]));
    z0im  = 35'(cj_im(smp[4], smp[5], smp[0], smp[1]))
          + 35'(cj_im(smp[8], smp[9], smp[2], smp[3]));
    z1re  = 35'(cj_re(smp[6], smp[7], smp[0], smp[1]))
          + 35'(cj_re(smp[10], smp[11], smp[2], smp[3]));
    z1im  = 35'(cj_im(smp[6], smp[7], smp[0], smp[1]))
          + 35'(cj_im(smp[10], smp[11], smp[2], smp[3]));
  end

  logic              v1_r, v2_r, v3_r;
  logic signed [GW-1:0] g00_r, g11_r, g01re_r, g01im_r, z0re_r, z0im_r, z1re_r, z1im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    g00_r   <= rnd4(g00);
    g11_r   <= rnd4(g11);
    g01re_r <= rnd4(g01re);
    g01im_r <= rnd4(g01im);
    z0re_r  <= rnd4(z0re);
    z0im_r  <= rnd4(z0im);
    z1re_r  <= rnd4(z1re);
    z1im_r  <= rnd4(z1im);
  end

  // stage 2: products
  logic signed [PW-1:0] pgg_r, prr_r, pii_r;
  logic signed [PW-1:0] a0_r, a1_r, b0_r, b1_r, b2_r, b3_r;
  logic signed [PW-1:0] c0_r, c1_r, d0_r, d1_r, d2_r, d3_r;

  always_ff @(posedge clk) begin
    pgg_r <= mul(g00_r, g11_r);
    prr_r <= mul(g01re_r, g01re_r);
    pii_r <= mul(g01im_r, g01im_r);
    a0_r  <= mul(g11_r, z0re_r);
    a1_r  <= mul(g11_r, z0im_r);
    b0_r  <= mul(g01re_r, z1re_r);
    b1_r  <= mul(g01im_r, z1im_r);
    b2_r  <= mul(g01re_r, z1im_r);
    b3_r  <= mul(g01im_r, z1re_r);
    c0_r  <= mul(g00_r, z1re_r);
    c1_r  <= mul(g00_r, z1im_r);
    d0_r  <= mul(g01re_r, z0re_r);
    d1_r  <= mul(g01im_r, z0im_r);
    d2_r  <= mul(g01re_r, z0im_r);
    d3_r  <= mul(g01im_r, z0re_r);
  end

  // stage 3: determinant and numerators
  logic signed [WW-1:0] det;
  lmd_pkg::work_t       work_nxt, work_r;

  always_comb begin
    det = WW'(pgg_r) - (WW'(prr_r) + WW'(pii_r));
    work_nxt.det    = (det < WW'(1)) ? WW'(1) : det;
    work_nxt.num[0] = WW'(a0_r) - (WW'(b0_r) - WW'(b1_r));
    work_nxt.num[1] = WW'(a1_r) - (WW'(b2_r) + WW'(b3_r));
    work_nxt.num[2] = WW'(c0_r) - (WW'(d0_r) + WW'(d1_r));
    work_nxt.num[3] = WW'(c1_r) - (WW'(d2_r) - WW'(d3_r));
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign push      = v3_r;
  assign push_data = work_r;

endmodule

[hdl/lmd_queue.sv]
// Queue between the front and back pipelines, with a registered read port.
// Depends on lmd_pkg and the assertion macro header.
`include "lmmse_mimo_2x2_detector_macros.svh"
module lmd_queue #(
  parameter int DEPTH = lmd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lmd_pkg::work_t    push_data,
  input  logic              pop,
  output lmd_pkg::work_t    pop_data,
  output lmd_pkg::q_stat_t  stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lmd_pkg::work_t   mem [DEPTH];
  lmd_pkg::work_t   rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign pop_data   = rd_data_r;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));

  `LMD_ASSERT(a_no_push_full, !(push && stat.full && !pop), "queue push while full")
  `LMD_ASSERT(a_no_pop_empty, !(pop && stat.empty), "queue pop while empty")

endmodule

[hdl/lmd_back.sv]
// Back pipeline: restoring divider per output component, rounding and saturation.
// Depends on lmd_pkg; pulls work from lmd_queue and drives the result channel.
module lmd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lmd_pkg::q_stat_t           q_stat,
  input  lmd_pkg::work_t             q_data,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lmd_pkg::OUT_W-1:0]  out_tdata,
  output logic [0:0]                 out_tuser
);

  localparam int QW = lmd_pkg::QUO_W;
  localparam int RW = lmd_pkg::REM_W;
  localparam int WW = lmd_pkg::WIDE_W;
  localparam int NL = lmd_pkg::NUM_LANES;
  localparam int DW = lmd_pkg::DATA_W;

  logic en;
  logic v0_r;

  logic          out_valid_r;
  logic [lmd_pkg::OUT_W-1:0] out_data_r;
  logic          out_clip_r;

  assign en  = !out_valid_r || out_tready;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= pop;
    end
  end

  logic             vld_r  [QW+1];
  logic [WW-1:0]    dv_r   [QW+1];
  lmd_pkg::lane_t   lane_r [QW+1][NL];

  // setup: sign, magnitude, overflow test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= v0_r;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_setup
    logic signed [WW-1:0] n;
    logic [WW-1:0]        mag;
    logic [RW-1:0]        num_sh;
    lmd_pkg::lane_t       ln;
    always_comb begin
      n          = $signed(q_data.num[l]);
      mag        = (n < 0) ? WW'(-n) : WW'(n);
      num_sh     = RW'(mag) << (lmd_pkg::OUT_FRAC + 1);
      ln.rem     = num_sh;
      ln.quo     = '0;
      ln.neg     = n < 0;
      ln.ovf     = num_sh >= (RW'(q_data.det) << QW);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lane_r[0][l] <= ln;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= q_data.det;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[s] <= dv_r[s-1];
      end
    end
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [RW-1:0]  sub;
      logic           ge;
      lmd_pkg::lane_t ln;
      always_comb begin
        sub    = RW'(dv_r[s-1]) << (QW - s);
        ge     = lane_r[s-1][l].rem >= sub;
        ln     = lane_r[s-1][l];
        ln.rem = ge ? lane_r[s-1][l].rem - sub : lane_r[s-1][l].rem;
        ln.quo = {lane_r[s-1][l].quo[QW-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          lane_r[s][l] <= ln;
        end
      end
    end
  end

  // round half away from zero, saturate
  logic [lmd_pkg::OUT_W-1:0] res;
  logic [NL-1:0]             clip;

  for (genvar l = 0; l < NL; l++) begin : g_final
    logic [QW:0]   q_inc;
    logic [QW-1:0] q;
    logic [QW-1:0] q_neg;
    always_comb begin
      q_inc = {1'b0, lane_r[QW][l].quo} + 1'b1;
      q     = q_inc[QW:1];
      q_neg = QW'(0) - q;
      if (lane_r[QW][l].neg) begin
        clip[l] = lane_r[QW][l].ovf || (q > lmd_pkg::NEG_MAX);
        res[DW*l +: DW] = clip[l] ? lmd_pkg::SAT_NEG : q_neg[DW-1:0];
      end else begin
        clip[l] = lane_r[QW][l].ovf || (q > lmd_pkg::POS_MAX);
        res[DW*l +: DW] = clip[l] ? lmd_pkg::SAT_POS : q[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
      out_clip_r <= |clip;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_clip_r;

endmodule

[hdl/lmmse_mimo_2x2_detector.sv]
// LMMSE detector for a 2x2 complex MIMO link, top level.
// Depends on lmd_pkg, lmd_front, lmd_queue, lmd_back and the macro header.
//
// Usage:
//   Input channel in_*: one beat per subcarrier sample, carrying y and H in
//   signed Q4.11. Result channel out_*: one beat per input beat, in order,
//   carrying x = (H^H H + I)^-1 H^H y in signed Q4.11 and a saturation flag.
//   Throughput: one beat per cycle while the result channel is not stalled.
//   The front pipeline (3 stages) runs freely into an 8-entry queue;
//   in_tready drops when the beats in the front pipeline plus the queue
//   fill all entries. The back part is a 17-stage restoring divider, one
//   quotient bit per stage, shared clock enable.
//   Stall: while out_tready is low with a beat held, the back part holds, the
//   queue fills, then in_tready falls. No beat is lost or repeated.
//   Reset: rst_n low clears all valid flags, pointers and the credit count;
//   the block accepts beats on the first cycle after reset.
`include "lmmse_mimo_2x2_detector_macros.svh"
module lmmse_mimo_2x2_detector #(
  parameter int QUEUE_DEPTH = lmd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // y0_re, y0_im, y1_re, y1_im, h00_re, h00_im, h01_re, h01_im,
  // h10_re, h10_im, h11_re, h11_im (16 bits each, lowest first)
  input  logic [lmd_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // x0_re, x0_im, x1_re, x1_im (16 bits each, lowest first)
  output logic [lmd_pkg::OUT_W-1:0]  out_tdata,
  // clipped
  output logic [0:0]                 out_tuser
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             in_fire;
  logic             push, pop;
  lmd_pkg::work_t   push_data, pop_data;
  lmd_pkg::q_stat_t q_stat;
  logic [CNT_W-1:0] credit_r, credit_nxt;

  assign in_tready = credit_r < CNT_W'(QUEUE_DEPTH);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    credit_nxt = credit_r;
    if (in_fire && !pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (pop && !in_fire) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  lmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_tdata),
    .push      (push),
    .push_data (push_data)
  );

  lmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  lmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `LMD_ASSERT(a_credit_bound, credit_r <= CNT_W'(QUEUE_DEPTH), "credit count above queue depth")
  `LMD_ASSERT_NEXT(a_pop_has_credit, pop && !in_fire, credit_r == $past(credit_r) - 1'b1, "pop without credit")

endmodule
